[sv/itda_pkg.sv]
// Shared constants, command/status types and sizing function for the decimal text converter.
package itda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  // Binary bits shifted into the decimal register per conversion cycle.
  localparam int STEP_BITS      = 4;
  localparam int CHAR_BITS      = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic load;
    logic step;
    logic lead;
    logic show_sign;
    logic show_digit;
  } itda_cmd_t;

  typedef struct packed {
    logic neg;
    logic idx_zero;
  } itda_status_t;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int itda_num_digits(input int bits);
    longint unsigned m;
    int n;
    m = 64'd1 << (bits - 1);
    n = 0;
    do begin
      n = n + 1;
      m = m / 10;
    end while (m != 0);
    return n;
  endfunction

endpackage

[sv/int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII text converter.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------------
//  input    | in_value                                | word taken when start && !busy
//  result   | out_character, out_last_char            | one character per cycle with out_strobe
//
// A word is converted in the shift-and-add-3 register (4 bits per cycle), its leading
// digit is found, then one output character (sign plus digits) is given per cycle.
// The next word is taken in the cycle after the last character.
// Reset returns the controller to idle; results cannot be stalled by the receiver.
module int_to_decimal_ascii #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [VALUE_BITS-1:0]           in_value,
  output logic                            out_strobe,
  output logic [itda_pkg::CHAR_BITS-1:0]  out_character,
  output logic                            out_last_char
);
  import itda_pkg::*;

  itda_cmd_t    cmd;
  itda_status_t status;

  itda_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  itda_dp #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk           (clk),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

[sv/itda_ctrl.sv]
// Controller state machine: sequences load, conversion, leading-digit search and text output.
module itda_ctrl #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  itda_pkg::itda_status_t status,
  output itda_pkg::itda_cmd_t    cmd
);
  import itda_pkg::*;

  localparam int NSTEP = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int CNTW  = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_LEAD  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNTW'(NSTEP - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_LEAD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_LEAD: begin
        cmd.lead  = 1'b1;
        state_nxt = status.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        cmd.show_sign = 1'b1;
        state_nxt     = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.show_digit = 1'b1;
        if (status.idx_zero) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/itda_dp.sv]
// Datapath: magnitude, shift-and-add-3 decimal conversion, leading digit index and character mux.
module itda_dp #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  itda_pkg::itda_cmd_t             cmd,
  output itda_pkg::itda_status_t          status,
  output logic                            out_strobe,
  output logic [itda_pkg::CHAR_BITS-1:0]  out_character,
  output logic                            out_last_char
);
  import itda_pkg::*;

  localparam int NSTEP = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD   = NSTEP * STEP_BITS;
  localparam int NDIG  = itda_num_digits(VALUE_BITS);
  localparam int IDXW  = $clog2(NDIG);

  logic [PAD-1:0]             bin_r, bin_nxt;
  logic [NDIG-1:0][3:0]       bcd_r, bcd_nxt;
  logic                       neg_r;
  logic [IDXW-1:0]            idx_r;
  logic [IDXW-1:0]            lead;
  logic [VALUE_BITS-1:0]      mag;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;

  // Four dependent double-dabble steps per cycle.
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_nxt[d] >= 4'd5) begin
          bcd_nxt[d] = bcd_nxt[d] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt, bin_nxt} << 1;
    end
  end

  // Highest nonzero digit; zero keeps index 0 so a single '0' is shown.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead = IDXW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= PAD'(mag);
      bcd_r <= '0;
      neg_r <= in_value[VALUE_BITS-1];
    end else if (cmd.step) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
    if (cmd.lead) begin
      idx_r <= lead;
    end else if (cmd.show_digit) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  assign status.neg      = neg_r;
  assign status.idx_zero = (idx_r == '0);

  assign out_strobe    = cmd.show_sign | cmd.show_digit;
  assign out_character = cmd.show_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_BITS'(bcd_r[idx_r]));
  assign out_last_char = cmd.show_digit & (idx_r == '0);

endmodule

[sv/itda_checker.sv]
// Port-level checker for the decimal text converter, bound to the top level.
module itda_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic [itda_pkg::CHAR_BITS-1:0] out_character,
  input logic                           out_last_char
);
  import itda_pkg::*;

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_character == CHAR_MINUS) ||
                    ((out_character >= CHAR_ZERO) &&
                     (out_character <= (CHAR_ZERO + CHAR_BITS'(9))))))
    else $error("character outside sign and digits");

  // A sign is always followed at once by a digit.
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_character == CHAR_MINUS)) |=>
      (out_strobe && (out_character != CHAR_MINUS)))
    else $error("sign not followed by a digit");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_char) |=> !busy)
    else $error("block stayed busy after the last character");

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);
